### rtl/core/sparse_weighted_channel_sum_macros.svh
// ----------------------------------------------------------------------------
// Sparse weighted channel sum: assertion macros
// Shared property templates for the checks in the core modules.
// ----------------------------------------------------------------------------
`ifndef SPARSE_WEIGHTED_CHANNEL_SUM_MACROS_SVH
`define SPARSE_WEIGHTED_CHANNEL_SUM_MACROS_SVH

// same-cycle implication
`define SWCS_ASSERT_IMPL(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("swcs: same-cycle check failed");

// next-cycle implication
`define SWCS_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("swcs: next-cycle check failed");

`endif

### rtl/core/swcs_pkg.sv
// ----------------------------------------------------------------------------
// Sparse weighted channel sum: package
// Shared types, register map and the result truncating, saturating function.
// ----------------------------------------------------------------------------
package swcs_pkg;

	localparam int ACC_W     = 48;
	localparam int PROD_W    = 32;
	localparam int RES_W     = 32;
	localparam int FRAC_BITS = 12;
	localparam int PADDR_W   = 3;

	localparam logic [PADDR_W-1:0] ADDR_NUM_ENTRIES = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_NUM_OUTPUTS = 3'd4;

	localparam logic OP_TABLE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic signed [RES_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [RES_W-1:0] RES_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic               op;
		logic [7:0]         entry_index;
		logic [3:0]         in_channel;
		logic [5:0]         in_element;
		logic [3:0]         out_channel;
		logic signed [15:0] weight;
		logic signed [15:0] sample;
		logic               block_end;
	} item_t;

	typedef struct packed {
		logic [3:0]         chan;
		logic [5:0]         elem;
		logic [3:0]         dest;
		logic signed [15:0] coef;
	} wrow_t;

	typedef struct packed {
		logic               vld;
		logic [3:0]         dest;
		logic signed [15:0] sample;
		logic signed [15:0] coef;
	} mac_req_t;

	typedef struct packed {
		logic clr;
		logic rd_en;
	} acc_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_READ,
		ST_LOAD,
		ST_SEND
	} state_t;

	function automatic logic signed [RES_W-1:0] sat_result(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-FRAC_BITS-1:0] q;
		logic signed [RES_W-1:0]           r;
		q = acc[ACC_W-1:FRAC_BITS];
		if (q[ACC_W-FRAC_BITS-1:RES_W-1] == '0 || q[ACC_W-FRAC_BITS-1:RES_W-1] == '1) begin
			r = q[RES_W-1:0];
		end else if (q[ACC_W-FRAC_BITS-1]) begin
			r = RES_MIN;
		end else begin
			r = RES_MAX;
		end
		return r;
	endfunction

endpackage

### rtl/core/swcs_fetch.sv
// ----------------------------------------------------------------------------
// Sparse weighted channel sum: table and sample fetch
// Holds the weight table and sample store, walks table rows and fetches
// the referenced sample for each row bound for an active output.
// ----------------------------------------------------------------------------
module swcs_fetch #(
	parameter int MAX_CHANNELS = 16,
	parameter int MAX_ELEMENTS = 64,
	parameter int MAX_ENTRIES  = 256,
	parameter int MAX_OUTPUTS  = 16,
	localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int OW  = $clog2(MAX_OUTPUTS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  swcs_pkg::item_t    item,
	input  logic               item_acc,
	input  logic               issue,
	input  logic [EAW-1:0]     issue_idx,
	input  logic [OW-1:0]      n_out,
	output swcs_pkg::mac_req_t req,
	output logic               busy
);
	import swcs_pkg::*;

	localparam int SDEPTH = MAX_CHANNELS * MAX_ELEMENTS;
	localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

	wrow_t              tab_mem [MAX_ENTRIES];
	logic signed [15:0] smp_mem [SDEPTH];

	wrow_t              tab_wdata;
	logic               tab_we;
	logic               smp_we;
	logic [EAW-1:0]     tab_waddr;
	logic [SAW-1:0]     smp_waddr;
	logic [SAW-1:0]     smp_raddr;
	logic               src_ok_s1;
	logic               dest_ok_s1;

	wrow_t              row_s1;
	logic               vld_s1;
	logic               vld_s2;
	logic               zero_s2;
	logic [3:0]         dest_s2;
	logic signed [15:0] coef_s2;
	logic signed [15:0] smp_s2;

	assign tab_we = item_acc && item.op == OP_TABLE && 32'(item.entry_index) < MAX_ENTRIES;
	assign smp_we = item_acc && item.op == OP_SAMPLE && 32'(item.in_channel) < MAX_CHANNELS
		&& 32'(item.in_element) < MAX_ELEMENTS;
	assign tab_waddr = EAW'(item.entry_index);
	assign smp_waddr = SAW'(32'(item.in_channel) * MAX_ELEMENTS + 32'(item.in_element));
	assign tab_wdata = '{chan: item.in_channel, elem: item.in_element,
		dest: item.out_channel, coef: item.weight};

	assign src_ok_s1  = 32'(row_s1.chan) < MAX_CHANNELS && 32'(row_s1.elem) < MAX_ELEMENTS;
	assign dest_ok_s1 = 32'(row_s1.dest) < 32'(n_out);
	assign smp_raddr  = SAW'(32'(row_s1.chan) * MAX_ELEMENTS + 32'(row_s1.elem));

	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_mem[tab_waddr] <= tab_wdata;
		end
		row_s1 <= tab_mem[issue_idx];
	end

	always_ff @(posedge clk) begin
		if (smp_we) begin
			smp_mem[smp_waddr] <= item.sample;
		end
		smp_s2 <= smp_mem[smp_raddr];
	end

	always_ff @(posedge clk) begin
		zero_s2 <= !src_ok_s1;
		dest_s2 <= row_s1.dest;
		coef_s2 <= row_s1.coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1 && dest_ok_s1;
		end
	end

	assign req.vld    = vld_s2;
	assign req.dest   = dest_s2;
	assign req.sample = zero_s2 ? '0 : smp_s2;
	assign req.coef   = coef_s2;
	assign busy       = vld_s1 || vld_s2;

endmodule

### rtl/core/swcs_accum.sv
// ----------------------------------------------------------------------------
// Sparse weighted channel sum: multiply-accumulate
// Multiplies sample by weight and adds into the accumulator memory by
// read-modify-write, forwarding the previous write on a same-entry hit.
// ----------------------------------------------------------------------------
`include "sparse_weighted_channel_sum_macros.svh"

module swcs_accum #(
	parameter int MAX_OUTPUTS = 16,
	localparam int AAW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  swcs_pkg::mac_req_t                  req,
	input  swcs_pkg::acc_ctl_t                  ctl,
	input  logic [AAW-1:0]                      rd_addr,
	output logic signed [swcs_pkg::ACC_W-1:0]   rd_data,
	output logic                                busy
);
	import swcs_pkg::*;

	logic signed [ACC_W-1:0]  acc_mem [MAX_OUTPUTS];
	logic [MAX_OUTPUTS-1:0]   acc_valid_q;

	logic [AAW-1:0]           raddr;
	logic                     vld_s3;
	logic [AAW-1:0]           dest_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [ACC_W-1:0]  rdata_s3;
	logic                     rvld_s3;
	logic                     fwd_vld_q;
	logic [AAW-1:0]           fwd_addr_q;
	logic signed [ACC_W-1:0]  fwd_data_q;
	logic signed [ACC_W-1:0]  old_val;
	logic signed [ACC_W-1:0]  sum;

	assign raddr = ctl.rd_en ? rd_addr : AAW'(req.dest);

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			acc_mem[dest_s3] <= sum;
		end
		rdata_s3 <= acc_mem[raddr];
	end

	always_ff @(posedge clk) begin
		rvld_s3    <= acc_valid_q[raddr];
		dest_s3    <= AAW'(req.dest);
		prod_s3    <= $signed(req.sample) * $signed(req.coef);
		fwd_addr_q <= dest_s3;
		fwd_data_q <= sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3      <= 1'b0;
			fwd_vld_q   <= 1'b0;
			acc_valid_q <= '0;
		end else begin
			vld_s3    <= req.vld;
			fwd_vld_q <= vld_s3;
			if (ctl.clr) begin
				acc_valid_q <= '0;
			end else if (vld_s3) begin
				acc_valid_q[dest_s3] <= 1'b1;
			end
		end
	end

	always_comb begin
		priority if (fwd_vld_q && fwd_addr_q == dest_s3) begin
			old_val = fwd_data_q;
		end else if (rvld_s3) begin
			old_val = rdata_s3;
		end else begin
			old_val = '0;
		end
	end

	assign sum     = old_val + {{(ACC_W-PROD_W){prod_s3[PROD_W-1]}}, prod_s3};
	assign rd_data = rvld_s3 ? rdata_s3 : '0;
	assign busy    = vld_s3;

	`SWCS_ASSERT_IMPL(a_no_read_in_walk, clk, arst_n, vld_s3 || req.vld, !ctl.rd_en)
	`SWCS_ASSERT_IMPL(a_clr_when_empty, clk, arst_n, ctl.clr, !vld_s3 && !req.vld)
	`SWCS_ASSERT_IMPL(a_fwd_marked, clk, arst_n, vld_s3 && fwd_vld_q && fwd_addr_q == dest_s3, acc_valid_q[dest_s3])

endmodule

### rtl/core/swcs_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse weighted channel sum: sequencer
// Accepts transactions, runs the table walk at block end, drains the
// pipeline and emits one truncated, saturated result per output.
// ----------------------------------------------------------------------------
`include "sparse_weighted_channel_sum_macros.svh"

module swcs_ctrl #(
	parameter int MAX_ENTRIES = 256,
	parameter int MAX_OUTPUTS = 16,
	localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CW  = $clog2(MAX_ENTRIES + 1),
	localparam int OW  = $clog2(MAX_OUTPUTS + 1),
	localparam int AAW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic                                block_end,
	input  logic [8:0]                          num_entries,
	input  logic [4:0]                          num_outputs,
	output logic [OW-1:0]                       n_out,
	output logic                                issue,
	output logic [EAW-1:0]                      issue_idx,
	output swcs_pkg::acc_ctl_t                  ctl,
	output logic [AAW-1:0]                      rd_addr,
	input  logic signed [swcs_pkg::ACC_W-1:0]   rd_data,
	input  logic                                busy,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [3:0]                          out_index,
	output logic signed [swcs_pkg::RES_W-1:0]   result_value,
	output logic                                last
);
	import swcs_pkg::*;

	state_t                 state_q;
	state_t                 state_d;
	logic [CW-1:0]          ecnt_q;
	logic [OW-1:0]          ocnt_q;
	logic [CW-1:0]          n_ent;
	logic                   blk_start;
	logic                   walk_last;
	logic                   out_last;
	logic [3:0]             out_index_q;
	logic signed [RES_W-1:0] result_q;
	logic                   last_q;

	always_comb begin
		n_ent = (32'(num_entries) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(num_entries);
		n_out = (32'(num_outputs) > MAX_OUTPUTS) ? OW'(MAX_OUTPUTS) : OW'(num_outputs);
	end

	assign blk_start = state_q == ST_IDLE && in_valid && op == OP_SAMPLE && block_end;
	assign walk_last = ecnt_q == n_ent - CW'(1);
	assign out_last  = ocnt_q == n_out - OW'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (blk_start) begin
					if (n_ent != '0) begin
						state_d = ST_WALK;
					end else if (n_out != '0) begin
						state_d = ST_READ;
					end
				end
			end
			ST_WALK: begin
				if (walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!busy) begin
					state_d = (n_out != '0) ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: state_d = ST_SEND;
			ST_SEND: begin
				if (!out_stall) begin
					state_d = out_last ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = state_q != ST_IDLE;
		issue     = state_q == ST_WALK;
		ctl.clr   = blk_start;
		ctl.rd_en = state_q == ST_READ;
		out_valid = state_q == ST_SEND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ecnt_q  <= '0;
			ocnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				ecnt_q <= '0;
				ocnt_q <= '0;
			end else begin
				if (state_q == ST_WALK) begin
					ecnt_q <= ecnt_q + CW'(1);
				end
				if (state_q == ST_SEND && !out_stall) begin
					ocnt_q <= ocnt_q + OW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			out_index_q <= 4'(ocnt_q);
			result_q    <= sat_result(rd_data);
			last_q      <= out_last;
		end
	end

	assign issue_idx    = ecnt_q[EAW-1:0];
	assign rd_addr      = ocnt_q[AAW-1:0];
	assign out_index    = out_index_q;
	assign result_value = result_q;
	assign last         = last_q;

	`SWCS_ASSERT_IMPL(a_walk_in_range, clk, arst_n, state_q == ST_WALK, 32'(ecnt_q) < 32'(n_ent))
	`SWCS_ASSERT_IMPL(a_read_in_range, clk, arst_n, state_q == ST_READ, 32'(ocnt_q) < 32'(n_out))
	`SWCS_ASSERT_NEXT(a_last_ends_block, clk, arst_n, out_valid && !out_stall && last, state_q == ST_IDLE)

endmodule

### rtl/core/sparse_weighted_channel_sum.sv
// ----------------------------------------------------------------------------
// Sparse weighted channel sum: top level
// Table writes and plain samples are accepted back to back.
// Block end: N table rows walked one a cycle, a pipeline drain, then each result
// is read, loaded and sent, held while out_stall is high; walk and drain are
// skipped when no rows are in use.
// Reset clears control and registers; stored tables and samples are kept.
// ----------------------------------------------------------------------------
module sparse_weighted_channel_sum #(
	parameter int MAX_CHANNELS = 16,
	parameter int MAX_ELEMENTS = 64,
	parameter int MAX_ENTRIES  = 256,
	parameter int MAX_OUTPUTS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [swcs_pkg::PADDR_W-1:0]         paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 op,
	input  logic [7:0]                           entry_index,
	input  logic [3:0]                           in_channel,
	input  logic [5:0]                           in_element,
	input  logic [3:0]                           out_channel,
	input  logic signed [15:0]                   weight,
	input  logic signed [15:0]                   sample,
	input  logic                                 block_end,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [3:0]                           out_index,
	output logic signed [swcs_pkg::RES_W-1:0]    result_value,
	output logic                                 last
);
	import swcs_pkg::*;

	localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OW  = $clog2(MAX_OUTPUTS + 1);
	localparam int AAW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

	logic [8:0]              num_entries_q;
	logic [4:0]              num_outputs_q;
	logic                    cfg_we;
	item_t                   item;
	logic                    item_acc;
	logic [OW-1:0]           n_out;
	logic                    issue;
	logic [EAW-1:0]          issue_idx;
	acc_ctl_t                acc_ctl;
	logic [AAW-1:0]          rd_addr;
	logic signed [ACC_W-1:0] rd_data;
	mac_req_t                req;
	logic                    fetch_busy;
	logic                    acc_busy;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_entries_q <= '0;
			num_outputs_q <= 5'd1;
		end else if (cfg_we) begin
			if (paddr == ADDR_NUM_ENTRIES) begin
				num_entries_q <= pwdata[8:0];
			end
			if (paddr == ADDR_NUM_OUTPUTS) begin
				num_outputs_q <= pwdata[4:0];
			end
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_NUM_ENTRIES: prdata = {23'b0, num_entries_q};
			ADDR_NUM_OUTPUTS: prdata = {27'b0, num_outputs_q};
			default:          prdata = '0;
		endcase
	end

	assign item = '{op: op, entry_index: entry_index, in_channel: in_channel,
		in_element: in_element, out_channel: out_channel, weight: weight,
		sample: sample, block_end: block_end};
	assign item_acc = in_valid && !in_stall;

	swcs_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MAX_OUTPUTS (MAX_OUTPUTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.block_end    (block_end),
		.num_entries  (num_entries_q),
		.num_outputs  (num_outputs_q),
		.n_out        (n_out),
		.issue        (issue),
		.issue_idx    (issue_idx),
		.ctl          (acc_ctl),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.busy         (fetch_busy || acc_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_index    (out_index),
		.result_value (result_value),
		.last         (last)
	);

	swcs_fetch #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.MAX_ENTRIES  (MAX_ENTRIES),
		.MAX_OUTPUTS  (MAX_OUTPUTS)
	) u_fetch (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.item_acc  (item_acc),
		.issue     (issue),
		.issue_idx (issue_idx),
		.n_out     (n_out),
		.req       (req),
		.busy      (fetch_busy)
	);

	swcs_accum #(
		.MAX_OUTPUTS (MAX_OUTPUTS)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.ctl     (acc_ctl),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.busy    (acc_busy)
	);

endmodule
